// ===== rtl/sadz_pkg.sv =====
package sadz_pkg;

	localparam int RAW_W     = 12;
	localparam int SUM_W     = 20;
	localparam int CNT_W     = 8;
	localparam int RCP_W     = SUM_W + 1;
	localparam int QP_W      = SUM_W + RCP_W;
	localparam int GAIN_W    = 16;
	localparam int PROD_W    = RAW_W + GAIN_W;
	localparam int SCL_W     = PROD_W + 15;
	localparam int SAT_W     = 15;
	localparam int OUT_W     = 16;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = ADDR_W - 2;

	localparam logic [IDX_W-1:0] REG_NEUTRAL_LOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_NEUTRAL_HIGH = 3'd1;
	localparam logic [IDX_W-1:0] REG_STABLE_DELTA = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEADZONE     = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN         = 3'd4;

	localparam logic [11:0] RST_NEUTRAL_LOW  = 12'd1500;
	localparam logic [11:0] RST_NEUTRAL_HIGH = 12'd2300;
	localparam logic [7:0]  RST_STABLE_DELTA = 8'd4;
	localparam logic [10:0] RST_DEADZONE     = 11'd163;
	localparam logic [15:0] RST_GAIN         = 16'd6963;

	localparam logic [RAW_W-1:0] CENTER_RST = 12'd2048;
	localparam logic [SAT_W-1:0] SAT_MAX    = 15'h7FFF;

	typedef struct packed {
		logic [11:0] neutral_low;
		logic [11:0] neutral_high;
		logic [7:0]  stable_delta;
		logic [10:0] deadzone_counts;
		logic [15:0] gain_q12;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic div;
		logic cal_write;
		logic offs;
		logic mul;
		logic scale;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic short_rpt;
		logic cal_due;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/sadz_regs.sv =====
module sadz_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sadz_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output sadz_pkg::cfg_t              cfg
);
	import sadz_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral_low     <= RST_NEUTRAL_LOW;
			cfg_q.neutral_high    <= RST_NEUTRAL_HIGH;
			cfg_q.stable_delta    <= RST_STABLE_DELTA;
			cfg_q.deadzone_counts <= RST_DEADZONE;
			cfg_q.gain_q12        <= RST_GAIN;
		end else if (wr_en) begin
			case (idx)
				REG_NEUTRAL_LOW:  cfg_q.neutral_low     <= pwdata[11:0];
				REG_NEUTRAL_HIGH: cfg_q.neutral_high    <= pwdata[11:0];
				REG_STABLE_DELTA: cfg_q.stable_delta    <= pwdata[7:0];
				REG_DEADZONE:     cfg_q.deadzone_counts <= pwdata[10:0];
				REG_GAIN:         cfg_q.gain_q12        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NEUTRAL_LOW:  prdata = {20'd0, cfg_q.neutral_low};
			REG_NEUTRAL_HIGH: prdata = {20'd0, cfg_q.neutral_high};
			REG_STABLE_DELTA: prdata = {24'd0, cfg_q.stable_delta};
			REG_DEADZONE:     prdata = {21'd0, cfg_q.deadzone_counts};
			REG_GAIN:         prdata = {16'd0, cfg_q.gain_q12};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/sadz_ctrl.sv =====
module sadz_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  sadz_pkg::dp_sts_t   sts,
	output sadz_pkg::dp_cmd_t   cmd
);
	import sadz_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_CALW  = 3'd3;
	localparam logic [2:0] ST_OFFS  = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_SCALE = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = !sts.short_rpt;
				if (sts.short_rpt) state_d = ST_EMIT;
				else if (sts.cal_due) state_d = ST_DIV;
				else state_d = ST_OFFS;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_CALW;
			end
			ST_CALW: begin
				cmd.cal_write = 1'b1;
				state_d = ST_OFFS;
			end
			ST_OFFS: begin
				cmd.offs = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/sadz_dp.sv =====
module sadz_dp #(
	parameter int SETTLE_RUN = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sadz_pkg::cfg_t      cfg,
	input  sadz_pkg::dp_cmd_t   cmd,
	output sadz_pkg::dp_sts_t   sts,
	input  logic [23:0]         s_tdata,
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [0:0]          m_tuser
);
	import sadz_pkg::*;

	localparam logic [CNT_W-1:0] CAL_N  = CNT_W'(SETTLE_RUN);
	localparam int               RCP_SH = SUM_W + $clog2(SETTLE_RUN);
	localparam logic [RCP_W-1:0] RCP_M  =
		RCP_W'(((1 << RCP_SH) + SETTLE_RUN - 1) / SETTLE_RUN);

	logic [RAW_W-1:0] rx_q, ry_q;
	logic             side_q, rot_q, short_q;

	logic [RAW_W-1:0] center_x_q [2];
	logic [RAW_W-1:0] center_y_q [2];
	logic [RAW_W-1:0] prev_x_q [2];
	logic [RAW_W-1:0] prev_y_q [2];
	logic             have_prev_q [2];
	logic [CNT_W-1:0] count_q [2];
	logic [SUM_W-1:0] sum_x_q [2];
	logic [SUM_W-1:0] sum_y_q [2];
	logic             cal_q [2];

	logic [SUM_W-1:0] div_x_q, div_y_q;
	logic [RAW_W-1:0] quo_x_q, quo_y_q;

	logic [RAW_W-1:0]  mag_x_q, mag_y_q;
	logic              neg_x_q, neg_y_q, zero_q, is_cal_q;
	logic [PROD_W-1:0] prod_x_q, prod_y_q;
	logic [SAT_W-1:0]  m_x_q, m_y_q;

	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic              m_tuser_q;

	logic [RAW_W-1:0] dif_x, dif_y;
	logic             in_band, stable;
	logic [CNT_W-1:0] cnt_inc;
	logic [SUM_W-1:0] sum_x_n, sum_y_n;
	logic             cal_due;

	logic [QP_W-1:0]  qp_x, qp_y;

	logic [RAW_W:0]   dx, dy;
	logic [RAW_W-1:0] adx, ady, mx, my;
	logic             dxn, dyn, nx, ny, dz;

	logic [SCL_W-1:0] t_x, t_y;
	logic [SUM_W-1:0] sh_x, sh_y;

	logic [OUT_W-1:0] ox, oy;

	// stability and calibration accumulation
	always_comb begin
		dif_x   = (rx_q >= prev_x_q[side_q]) ? rx_q - prev_x_q[side_q] : prev_x_q[side_q] - rx_q;
		dif_y   = (ry_q >= prev_y_q[side_q]) ? ry_q - prev_y_q[side_q] : prev_y_q[side_q] - ry_q;
		in_band = (rx_q >= cfg.neutral_low) && (rx_q <= cfg.neutral_high) &&
		          (ry_q >= cfg.neutral_low) && (ry_q <= cfg.neutral_high);
		stable  = in_band && (!have_prev_q[side_q] ||
		          ((dif_x <= {4'd0, cfg.stable_delta}) && (dif_y <= {4'd0, cfg.stable_delta})));
		cnt_inc = count_q[side_q] + 1'b1;
		sum_x_n = sum_x_q[side_q] + {{(SUM_W-RAW_W){1'b0}}, rx_q};
		sum_y_n = sum_y_q[side_q] + {{(SUM_W-RAW_W){1'b0}}, ry_q};
		cal_due = stable && (cnt_inc >= CAL_N);
	end

	// divide by the run length as a multiply by its reciprocal
	always_comb begin
		qp_x = div_x_q * RCP_M;
		qp_y = div_y_q * RCP_M;
	end

	// offsets, rotation, dead zone
	always_comb begin
		dx  = {1'b0, rx_q} - {1'b0, center_x_q[side_q]};
		dy  = {1'b0, ry_q} - {1'b0, center_y_q[side_q]};
		dxn = dx[RAW_W];
		dyn = dy[RAW_W];
		adx = dxn ? RAW_W'(-dx) : dx[RAW_W-1:0];
		ady = dyn ? RAW_W'(-dy) : dy[RAW_W-1:0];
		if (rot_q) begin
			mx = ady;
			my = adx;
			nx = side_q ? dyn : !dyn;
			ny = side_q ? dxn : !dxn;
		end else begin
			mx = adx;
			my = ady;
			nx = dxn;
			ny = !dyn;
		end
		dz = (mx <= {1'b0, cfg.deadzone_counts}) && (my <= {1'b0, cfg.deadzone_counts});
	end

	// times 32767 as shift and subtract, then drop 23 bits and saturate
	always_comb begin
		t_x  = {prod_x_q, 15'd0} - {15'd0, prod_x_q};
		t_y  = {prod_y_q, 15'd0} - {15'd0, prod_y_q};
		sh_x = t_x[SCL_W-1:23];
		sh_y = t_y[SCL_W-1:23];
	end

	always_comb begin
		ox = neg_x_q ? OUT_W'(-{1'b0, m_x_q}) : {1'b0, m_x_q};
		oy = neg_y_q ? OUT_W'(-{1'b0, m_y_q}) : {1'b0, m_y_q};
	end

	assign sts.short_rpt = short_q;
	assign sts.cal_due   = cal_due;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				center_x_q[i]  <= CENTER_RST;
				center_y_q[i]  <= CENTER_RST;
				prev_x_q[i]    <= '0;
				prev_y_q[i]    <= '0;
				have_prev_q[i] <= 1'b0;
				count_q[i]     <= '0;
				sum_x_q[i]     <= '0;
				sum_y_q[i]     <= '0;
				cal_q[i]       <= 1'b0;
			end
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				prev_x_q[side_q]    <= rx_q;
				prev_y_q[side_q]    <= ry_q;
				have_prev_q[side_q] <= 1'b1;
				if (!stable || cal_due) begin
					count_q[side_q] <= '0;
					sum_x_q[side_q] <= '0;
					sum_y_q[side_q] <= '0;
				end else begin
					count_q[side_q] <= cnt_inc;
					sum_x_q[side_q] <= sum_x_n;
					sum_y_q[side_q] <= sum_y_n;
				end
			end
			if (cmd.cal_write) begin
				center_x_q[side_q] <= quo_x_q;
				center_y_q[side_q] <= quo_y_q;
				cal_q[side_q]      <= 1'b1;
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rx_q    <= {s_tdata[11:8], s_tdata[7:0]};
			ry_q    <= {s_tdata[23:16], s_tdata[15:12]};
			side_q  <= s_tuser[0];
			rot_q   <= s_tuser[1];
			short_q <= s_tuser[2];
		end
		if (cmd.eval) begin
			div_x_q <= sum_x_n;
			div_y_q <= sum_y_n;
		end
		if (cmd.div) begin
			quo_x_q <= qp_x[RCP_SH +: RAW_W];
			quo_y_q <= qp_y[RCP_SH +: RAW_W];
		end
		if (cmd.offs) begin
			mag_x_q  <= mx;
			mag_y_q  <= my;
			neg_x_q  <= nx;
			neg_y_q  <= ny;
			is_cal_q <= cal_q[side_q];
			zero_q   <= !cal_q[side_q] || dz;
		end
		if (cmd.mul) begin
			prod_x_q <= mag_x_q * cfg.gain_q12;
			prod_y_q <= mag_y_q * cfg.gain_q12;
		end
		if (cmd.scale) begin
			m_x_q <= (sh_x > {{(SUM_W-SAT_W){1'b0}}, SAT_MAX}) ? SAT_MAX : sh_x[SAT_W-1:0];
			m_y_q <= (sh_y > {{(SUM_W-SAT_W){1'b0}}, SAT_MAX}) ? SAT_MAX : sh_y[SAT_W-1:0];
		end
		if (cmd.emit) begin
			if (short_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b0;
			end else begin
				m_tdata_q <= zero_q ? 32'd0 : {oy, ox};
				m_tuser_q <= is_cal_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/stick_autocal_deadzone_scaler_unit.sv =====
// Stick conditioning unit: unpacks 12-bit X/Y from three stick bytes, keeps a
// separate auto-centering calibration for the left and right controller, then
// applies sideways rotation, a dead zone and a Q4.12 gain.
// Input stream (s_t*): one beat per report, accepted when s_tvalid && s_tready.
// Output stream (m_t*): one beat per input beat, in order, held while
// m_tready is low. A registered output lets the next report enter while a
// result still waits; that report then holds in the emit step and the input stalls.
// The controller takes each report through accept, evaluate, offset, multiply,
// scale and emit; a short report goes from evaluate straight to emit.
// The report that completes a calibration run also takes a divide step, where
// a reciprocal multiply divides the sample sums, and then writes the new center.
// The input is not ready again until the report's result has been emitted.
// Reset puts both sides back to uncalibrated with center 2048 and restores
// the register defaults; results are zero until a side is calibrated.
// Registers (APB, byte address 4*i): neutral_low, neutral_high, stable_delta,
// deadzone_counts, gain_q12.
module stick_autocal_deadzone_scaler_unit #(
	parameter int SETTLE_RUN = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sadz_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [23:0]                 s_tdata,  // stick_byte0, stick_byte1, stick_byte2
	input  logic [2:0]                  s_tuser,  // right_side, sideways, report_short
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // stick_x, stick_y
	output logic [0:0]                  m_tuser   // is_calibrated
);
	import sadz_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	sadz_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sadz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sadz_dp #(
		.SETTLE_RUN (SETTLE_RUN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("uncalibrated result carries nonzero position");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a report is in progress");

	a_no_min_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000)))
		else $error("scaled output exceeds 32767 in magnitude");
`endif

endmodule
